### rtl/core/dpni_pkg.sv
// Shared constants for the dead pixel neighbour interpolator.
`default_nettype none

package dpni_pkg;

	// Default build parameters.
	localparam int MAX_COLS_DEF   = 128;
	localparam int PIXEL_BITS_DEF = 16;

	// Configuration register file layout.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int ROWS_W     = 10;
	localparam int COLS_REG_W = 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	// Register reset values.
	localparam logic [ROWS_W-1:0]     FRAME_ROWS_RST = 10'd80;
	localparam logic [COLS_REG_W-1:0] FRAME_COLS_RST = 8'd80;

	// Width wide enough to compare a column register against any column limit.
	localparam int COLS_CMP_W = 11;

	// Depth of the job queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;

	// Width of the neighbour count (zero to eight).
	localparam int CNT_W = 4;

endpackage

`default_nettype wire

### rtl/core/dpni_ram.sv
// Generic simple dual port RAM with registered read data.
`default_nettype none

module dpni_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/dpni_queue.sv
// Small job queue that decouples the front end from the back end.
`default_nettype none

module dpni_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/dpni_front.sv
// Front end: accepts pixels, writes the history store and queues output jobs.
`default_nettype none

module dpni_front #(
	parameter int MAX_COLS   = dpni_pkg::MAX_COLS_DEF,
	parameter int PIXEL_BITS = dpni_pkg::PIXEL_BITS_DEF,
	parameter int AW         = 9
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                restart,
	input  wire logic [dpni_pkg::ROWS_W-1:0]         rows,
	input  wire logic [$clog2(MAX_COLS+1)-1:0]       cols,
	input  wire logic                                pix_valid,
	output logic                                     pix_stall,
	input  wire logic signed [PIXEL_BITS-1:0]        pixel_in,
	input  wire logic                                flush,
	input  wire logic                                q_full,
	output logic                                     q_push,
	output logic      [AW:0]                         q_data,
	output logic                                     mem_we,
	output logic      [AW-1:0]                       mem_waddr,
	output logic      [PIXEL_BITS-1:0]               mem_wdata
);

	localparam int CNW  = $clog2(MAX_COLS + 1);
	localparam int CIW  = $clog2(MAX_COLS);
	localparam int PW   = $clog2(MAX_COLS + 3);

	logic [AW-1:0]                   wp_q;
	logic [PW-1:0]                   pending_q;
	logic [dpni_pkg::ROWS_W-1:0]     in_row_q;
	logic [CIW-1:0]                  in_col_q;
	logic                            emitted_q;

	logic          accept;
	logic          at_start;
	logic          drain;
	logic          write;
	logic [PW-1:0] pend_inc;
	logic [PW-1:0] cols_p1;
	logic          emit_wr;
	logic          emit_dr;
	logic [AW-1:0] base;
	logic          last_col;

	// Item classification.
	always_comb begin
		accept   = pix_valid && !q_full;
		at_start = (in_row_q == '0) && (in_col_q == '0);
		drain    = accept && flush && at_start;
		write    = accept && !(flush && at_start);
		pend_inc = pending_q + 1'b1;
		cols_p1  = PW'(cols) + 1'b1;
		emit_wr  = write && (pend_inc > cols_p1);
		emit_dr  = drain && (pending_q != '0);
		last_col = (CNW'(in_col_q) == cols - 1'b1);
		if (drain) begin
			base = wp_q - AW'(pending_q);
		end else begin
			base = wp_q + 1'b1 - AW'(pend_inc);
		end
	end

	assign pix_stall = q_full;
	assign q_push    = emit_wr || emit_dr;
	assign q_data    = {!emitted_q, base};
	assign mem_we    = write;
	assign mem_waddr = wp_q;
	assign mem_wdata = flush ? '0 : pixel_in;

	// Input position, write pointer and pending count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			pending_q <= '0;
			in_row_q  <= '0;
			in_col_q  <= '0;
			emitted_q <= 1'b0;
		end else if (restart) begin
			pending_q <= '0;
			in_row_q  <= '0;
			in_col_q  <= '0;
			emitted_q <= 1'b0;
		end else begin
			if (q_push) begin
				emitted_q <= 1'b1;
			end
			if (emit_dr) begin
				pending_q <= pending_q - 1'b1;
			end
			if (write) begin
				wp_q <= wp_q + 1'b1;
				if (!emit_wr) begin
					pending_q <= pend_inc;
				end
				if (last_col) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q == rows - 1'b1) ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/dpni_div.sv
// Iterative divider of a neighbour sum by a small count, eight bits per cycle.
`default_nettype none

module dpni_div #(
	parameter int DW = 19
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DW-1:0]                 dividend,
	input  wire logic [dpni_pkg::CNT_W-1:0]    divisor,
	output logic                               done,
	output logic      [DW-1:0]                 quotient
);

	localparam int STEP  = 8;
	localparam int NIT   = (DW + STEP - 1) / STEP;
	localparam int PADW  = NIT * STEP;
	localparam int ITW   = $clog2(NIT + 1);
	localparam int CW    = dpni_pkg::CNT_W;

	logic [PADW-1:0] dvd_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   div_q;
	logic [ITW-1:0]  iter_q;
	logic            busy_q;
	logic            done_q;

	logic [PADW-1:0] dvd_n;
	logic [CW:0]     rem_n;

	// Eight restoring steps on the narrow remainder.
	always_comb begin
		dvd_n = dvd_q;
		rem_n = {1'b0, rem_q};
		for (int i = 0; i < STEP; i++) begin
			rem_n = {rem_n[CW-1:0], dvd_n[PADW-1]};
			dvd_n = {dvd_n[PADW-2:0], 1'b0};
			if (rem_n >= {1'b0, div_q}) begin
				rem_n    = rem_n - {1'b0, div_q};
				dvd_n[0] = 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q[DW-1:0];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITW'(NIT - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= PADW'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n[CW-1:0];
		end
	end

endmodule

`default_nettype wire

### rtl/core/dpni_back.sv
// Back end: builds the 3x3 window from the store, averages and drives results.
`default_nettype none

module dpni_back #(
	parameter int MAX_COLS   = dpni_pkg::MAX_COLS_DEF,
	parameter int PIXEL_BITS = dpni_pkg::PIXEL_BITS_DEF,
	parameter int AW         = 9
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             restart,
	input  wire logic [dpni_pkg::ROWS_W-1:0]      rows,
	input  wire logic [$clog2(MAX_COLS+1)-1:0]    cols,
	input  wire logic                             q_empty,
	output logic                                  q_pop,
	input  wire logic [AW:0]                      q_data,
	output logic                                  mem_re,
	output logic      [AW-1:0]                    mem_raddr,
	input  wire logic [PIXEL_BITS-1:0]            mem_rdata,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic signed [PIXEL_BITS-1:0]          pixel_out,
	output logic                                  corrected,
	output logic                                  last_of_frame
);

	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int CIW = $clog2(MAX_COLS);
	localparam int PB  = PIXEL_BITS;
	localparam int SW  = PIXEL_BITS + 3;
	localparam int CW  = dpni_pkg::CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam logic [1:0] RK_TOP = 2'd0;
	localparam logic [1:0] RK_MID = 2'd1;
	localparam logic [1:0] RK_BOT = 2'd2;

	logic [2:0]                  state_q;
	logic [AW-1:0]               col_pos_q;
	logic                        more_q;
	logic                        issuing_q;
	logic [1:0]                  rk_q;
	logic                        rv_s1;
	logic [1:0]                  rk_s1;
	logic                        last_s1;
	logic [PB-1:0]               top_q;
	logic [PB-1:0]               mid_q;
	logic [PB-1:0]               win_q [3][3];
	logic [dpni_pkg::ROWS_W-1:0] out_row_q;
	logic [CIW-1:0]              out_col_q;
	logic [PB-1:0]               center_q;
	logic                        need_div_q;
	logic                        res_valid_q;
	logic [PB-1:0]               pixel_out_q;
	logic                        corrected_q;
	logic                        last_q;

	logic [AW-1:0] ofs;
	logic          top_m;
	logic          bot_m;
	logic          left_m;
	logic          right_m;
	logic [SW-1:0] sum_c;
	logic [CW-1:0] cnt_c;
	logic          need_div_c;
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] quot;
	logic          out_free;
	logic          at_last;

	// Read address: one column of the window, top to bottom.
	always_comb begin
		case (rk_q)
			RK_TOP:  ofs = '0 - AW'(cols);
			RK_MID:  ofs = '0;
			RK_BOT:  ofs = AW'(cols);
			default: ofs = '0;
		endcase
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign mem_re    = (state_q == ST_READ) && issuing_q;
	assign mem_raddr = col_pos_q + ofs;

	// Border masks and the sum of strictly positive neighbours.
	always_comb begin
		top_m   = (out_row_q == '0);
		bot_m   = (out_row_q == rows - 1'b1);
		left_m  = (out_col_q == '0);
		right_m = (CNW'(out_col_q) == cols - 1'b1);
		at_last = bot_m && right_m;
		sum_c   = '0;
		cnt_c   = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1) &&
				    !(r == 0 && top_m) && !(r == 2 && bot_m) &&
				    !(c == 0 && left_m) && !(c == 2 && right_m) &&
				    !win_q[r][c][PB-1] && (win_q[r][c] != '0)) begin
					sum_c = sum_c + SW'(win_q[r][c]);
					cnt_c = cnt_c + 1'b1;
				end
			end
		end
		need_div_c = (win_q[1][1] == '0) && (cnt_c != '0);
	end

	assign div_start = (state_q == ST_SUM) && need_div_c;

	dpni_div #(
		.DW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_c),
		.divisor  (cnt_c),
		.done     (div_done),
		.quotient (quot)
	);

	assign out_free      = !res_valid_q || !res_stall;
	assign res_valid     = res_valid_q;
	assign pixel_out     = pixel_out_q;
	assign corrected     = corrected_q;
	assign last_of_frame = last_q;

	// Sequencer for reads, arithmetic and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			more_q      <= 1'b0;
			issuing_q   <= 1'b0;
			rk_q        <= RK_TOP;
			rv_s1       <= 1'b0;
			rk_s1       <= RK_TOP;
			last_s1     <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rv_s1   <= mem_re;
			rk_s1   <= rk_q;
			last_s1 <= !more_q && (rk_q == RK_BOT);
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (restart) begin
				out_row_q <= '0;
				out_col_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						more_q    <= q_data[AW];
						col_pos_q <= q_data[AW] ? q_data[AW-1:0] : q_data[AW-1:0] + 1'b1;
						rk_q      <= RK_TOP;
						issuing_q <= 1'b1;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					if (issuing_q) begin
						if (rk_q == RK_BOT) begin
							rk_q <= RK_TOP;
							if (more_q) begin
								more_q    <= 1'b0;
								col_pos_q <= col_pos_q + 1'b1;
							end else begin
								issuing_q <= 1'b0;
							end
						end else begin
							rk_q <= rk_q + 1'b1;
						end
					end
					if (rv_s1 && (rk_s1 == RK_BOT) && last_s1) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= need_div_c ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (right_m) begin
							out_col_q <= '0;
							out_row_q <= bot_m ? '0 : out_row_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window columns and result payload.
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			case (rk_s1)
				RK_TOP: top_q <= mem_rdata;
				RK_MID: mid_q <= mem_rdata;
				RK_BOT: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= win_q[r][2];
					end
					win_q[0][2] <= top_q;
					win_q[1][2] <= mid_q;
					win_q[2][2] <= mem_rdata;
				end
				default: top_q <= top_q;
			endcase
		end
		if (state_q == ST_SUM) begin
			center_q   <= win_q[1][1];
			need_div_q <= need_div_c;
		end
		if ((state_q == ST_OUT) && out_free) begin
			pixel_out_q <= need_div_q ? quot[PB-1:0] : center_q;
			corrected_q <= need_div_q;
			last_q      <= at_last;
		end
	end

endmodule

`default_nettype wire

### rtl/core/dead_pixel_neighbour_interpolator_unit.sv
// Top level of the dead pixel neighbour interpolator.
//
// Pixels enter in raster order on the pix channel (pix_valid, pix_stall,
// pixel_in, flush). A zero pixel is replaced by the truncated mean of its
// strictly positive eight neighbours in the raw frame; the border counts as zero.
// Results leave on the res channel (res_valid, res_stall, pixel_out,
// corrected, last_of_frame), one row plus one pixel behind the input.
// Flush items at the start of a frame drain the last row of the previous one.
// The front end takes one pixel per cycle while the four-entry job queue is not
// full. The back end reads three history words per result (six for the first
// result after a restart) from one RAM read port, sums, and divides eight
// quotient bits per cycle; it finishes one result before it takes the next job
// from the queue, and so sets the sustained rate.
// A result waits in the output register while res_stall is high, and the
// back end then holds; the front end keeps taking pixels until the queue is full.
// Reset clears positions and the output register; frame size resets to 80x80.
// A write to a frame size register (cfg_valid, cfg_ready) restarts the stream.
`default_nettype none

module dead_pixel_neighbour_interpolator_unit #(
	parameter int MAX_COLS   = dpni_pkg::MAX_COLS_DEF,
	parameter int PIXEL_BITS = dpni_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [dpni_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dpni_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                pix_valid,
	output logic                                     pix_stall,
	input  wire logic signed [PIXEL_BITS-1:0]        pixel_in,
	input  wire logic                                flush,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output logic signed [PIXEL_BITS-1:0]             pixel_out,
	output logic                                     corrected,
	output logic                                     last_of_frame
);

	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int AW  = $clog2(2 * MAX_COLS + dpni_pkg::QUEUE_DEPTH + 8);
	localparam int CMW = dpni_pkg::COLS_CMP_W;

	logic [dpni_pkg::ROWS_W-1:0]     frame_rows_q;
	logic [dpni_pkg::COLS_REG_W-1:0] frame_cols_q;
	logic                            cfg_wr;
	logic                            restart;
	logic [dpni_pkg::ROWS_W-1:0]     erows;
	logic [CMW-1:0]                  cols_ext;
	logic [CNW-1:0]                  ecols;

	logic          q_full;
	logic          q_empty;
	logic          q_push;
	logic          q_pop;
	logic [AW:0]   q_in;
	logic [AW:0]   q_out;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [PIXEL_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [PIXEL_BITS-1:0] mem_rdata;

	// Configuration register file.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && ((cfg_index == dpni_pkg::REG_FRAME_ROWS) ||
	                              (cfg_index == dpni_pkg::REG_FRAME_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= dpni_pkg::FRAME_ROWS_RST;
			frame_cols_q <= dpni_pkg::FRAME_COLS_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				dpni_pkg::REG_FRAME_ROWS: frame_rows_q <= cfg_data;
				dpni_pkg::REG_FRAME_COLS: frame_cols_q <= cfg_data[dpni_pkg::COLS_REG_W-1:0];
				default: frame_rows_q <= frame_rows_q;
			endcase
		end
	end

	// Effective frame size: zero acts as one, columns clip to the store width.
	always_comb begin
		erows    = (frame_rows_q == '0) ? 10'd1 : frame_rows_q;
		cols_ext = CMW'(frame_cols_q);
		if (cols_ext == '0) begin
			ecols = CNW'(1);
		end else if (cols_ext > CMW'(MAX_COLS)) begin
			ecols = CNW'(MAX_COLS);
		end else begin
			ecols = cols_ext[CNW-1:0];
		end
	end

	dpni_front #(
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS),
		.AW         (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.rows      (erows),
		.cols      (ecols),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_in  (pixel_in),
		.flush     (flush),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	dpni_queue #(
		.WIDTH (AW + 1),
		.DEPTH (dpni_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (restart),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	dpni_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (2 ** AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dpni_back #(
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS),
		.AW         (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.rows          (erows),
		.cols          (ecols),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_data        (q_out),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixel_out     (pixel_out),
		.corrected     (corrected),
		.last_of_frame (last_of_frame)
	);

endmodule

`default_nettype wire

### tb/tb_dead_pixel_neighbour_interpolator_unit.sv
// Self-checking testbench for the dead pixel neighbour interpolator unit.
`default_nettype none

module tb_dead_pixel_neighbour_interpolator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXC = dpni_pkg::MAX_COLS_DEF;
	localparam int PB = dpni_pkg::PIXEL_BITS_DEF;
	localparam int IW = dpni_pkg::CFG_IDX_W;
	localparam int DW = dpni_pkg::CFG_DATA_W;
	localparam int HIST = 2 * MAXC + 4;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE = 40;
	// Indexes outside the register file; a write there must change nothing.
	localparam logic [IW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IW-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic signed [PB-1:0] pix;
		logic                 fl;
	} pix_item_t;

	typedef struct {
		logic signed [PB-1:0] pix;
		logic                 cor;
		logic                 last;
	} pix_result_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [IW-1:0] cfg_index;
	logic [DW-1:0] cfg_data;
	logic pix_valid, pix_stall, flush;
	logic signed [PB-1:0] pixel_in;
	logic res_valid, res_stall, corrected, last_of_frame;
	logic signed [PB-1:0] pixel_out;

	dead_pixel_neighbour_interpolator_unit dut (.*);

	// Stimulus waiting to be driven and corrected pixels waiting to arrive.
	pix_item_t   pixel_feed[$];
	pix_result_t corrected_q[$];

	// Shadow of the block: frame size, raw pixel history and positions.
	int unsigned rows_reg, cols_reg;
	int          raw_hist[HIST];
	int unsigned hist_wp, in_row, in_col, out_row, out_col, backlog;

	int errors, results_seen, items_sent, idle_cycles;
	bit burst, hold_output;
	int unsigned src_gap, sink_gap, sink_draw;

	function automatic int unsigned rows_eff();
		return rows_reg == 0 ? 1 : rows_reg;
	endfunction

	function automatic int unsigned cols_eff();
		int unsigned c;
		c = cols_reg == 0 ? 1 : cols_reg;
		return c > MAXC ? MAXC : c;
	endfunction

	function automatic void restart_stream();
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; backlog = 0;
	endfunction

	// Build the 3x3 neighbourhood of the oldest pending pixel and queue its result.
	function automatic void emit_pixel();
		int unsigned rows, cols, base, idx;
		int r, c, off, v, res, cnt;
		longint sum;
		pix_result_t e;
		rows = rows_eff(); cols = cols_eff();
		base = (hist_wp + HIST - backlog) % HIST;
		sum = 0; cnt = 0; res = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				r = int'(out_row) + dr;
				c = int'(out_col) + dc;
				off = dr * int'(cols) + dc;
				v = 0;
				if (r >= 0 && r < int'(rows) && c >= 0 && c < int'(cols) &&
						off < int'(backlog) && off > -HIST + int'(backlog)) begin
					idx = (base + 2 * HIST + off) % HIST;
					v = raw_hist[idx];
				end
				if (dr == 0 && dc == 0)
					res = v;
				else if (v > 0) begin
					sum += v;
					cnt++;
				end
			end
		end
		e.cor = 0;
		if (res == 0 && cnt > 0) begin
			res = int'(sum / cnt);
			e.cor = 1;
		end
		e.pix = res[PB-1:0];
		e.last = (out_row == rows - 1 && out_col == cols - 1);
		corrected_q.push_back(e);
		backlog--;
		out_col++;
		if (out_col >= cols) begin
			out_col = 0;
			out_row++;
			if (out_row >= rows)
				out_row = 0;
		end
	endfunction

	// Advance the shadow by one accepted pixel transaction.
	function automatic void take_pixel(logic signed [PB-1:0] pix, logic fl);
		int unsigned cols;
		cols = cols_eff();
		if (fl && in_row == 0 && in_col == 0) begin
			if (backlog != 0)
				emit_pixel();
			return;
		end
		raw_hist[hist_wp] = fl ? 0 : int'(pix);
		hist_wp = (hist_wp + 1) % HIST;
		if (backlog < cols + 2)
			backlog++;
		in_col++;
		if (in_col >= cols) begin
			in_col = 0;
			in_row++;
			if (in_row >= rows_eff())
				in_row = 0;
		end
		if (backlog > cols + 1)
			emit_pixel();
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Driver: presents queued pixels with random gaps and updates the shadow.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 0;
			pixel_in <= '0;
			flush <= 0;
			src_gap <= 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				take_pixel(pixel_in, flush);
				items_sent++;
				if (items_sent % 64 == 0)
					burst = ($urandom_range(0, 3) == 0);
			end
			if (pix_valid && pix_stall) begin
				// Hold the stalled payload.
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				pix_valid <= 0;
			end else if (pixel_feed.size() != 0) begin
				pix_item_t it;
				it = pixel_feed.pop_front();
				pix_valid <= 1;
				pixel_in <= it.pix;
				flush <= it.fl;
				src_gap <= burst ? 0 : $urandom_range(0, 5);
			end else
				pix_valid <= 0;
		end
	end

	// Monitor: checks each result transaction and draws the next stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1;
			sink_gap <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (corrected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result pix=%0d cor=%0b last=%0b",
							pixel_out, corrected, last_of_frame);
				end else begin
					pix_result_t e;
					e = corrected_q.pop_front();
					if (e.pix !== pixel_out || e.cor !== corrected ||
							e.last !== last_of_frame) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp pix=%0d cor=%0b last=%0b got pix=%0d cor=%0b last=%0b",
								e.pix, e.cor, e.last, pixel_out, corrected, last_of_frame);
					end
				end
				sink_draw = burst ? 0 : $urandom_range(0, 5);
				sink_gap <= (sink_draw > 0) ? sink_draw - 1 : 0;
				res_stall <= hold_output || (sink_draw > 0);
			end else if (hold_output) begin
				res_stall <= 1;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				res_stall <= 1;
			end else
				res_stall <= 0;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d results outstanding", corrected_q.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Wait until every pixel is accepted and every result has arrived.
	task automatic wait_drained();
		while (pixel_feed.size() != 0 || pix_valid || corrected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == dpni_pkg::REG_FRAME_ROWS) begin
			rows_reg = val;
			restart_stream();
		end else if (idx == dpni_pkg::REG_FRAME_COLS) begin
			cols_reg = val[dpni_pkg::COLS_REG_W-1:0];
			restart_stream();
		end
	endtask

	function automatic void push_pixel(int v, logic fl);
		pix_item_t it;
		it.pix = v[PB-1:0];
		it.fl = fl;
		pixel_feed.push_back(it);
	endfunction

	// Mostly zeros and positives so corrections happen often.
	function automatic int rand_pixel();
		case ($urandom_range(0, 9))
			0, 1, 2: return 0;
			3: return -int'($urandom_range(0, 32768));
			4: return $urandom_range(0, 1) ? 32767 : -32768;
			5: return int'($urandom_range(0, 65535)) - 32768;
			default: return $urandom_range(1, 32767);
		endcase
	endfunction

	// Back-to-back frames with random content, then flushes to drain.
	task automatic run_frames(int unsigned nitems, int flush_pct);
		int unsigned frame, pos;
		frame = rows_eff() * cols_eff();
		pos = 0;
		for (int unsigned i = 0; i < nitems; i++) begin
			if ($urandom_range(0, 99) < flush_pct)
				push_pixel(rand_pixel(), 1);
			else
				push_pixel(rand_pixel(), 0);
			pos++;
		end
		for (int unsigned i = 0; i < (frame - pos % frame) % frame + cols_eff() + 2; i++)
			push_pixel($urandom, 1);
		wait_drained();
	endtask

	initial begin
		static int dir_pix[12] = '{0, 32767, -32768, 0, 5, 0, 0, 1, 0, -1, 7, 0};
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		burst = 0; hold_output = 0;
		errors = 0; results_seen = 0; items_sent = 0; idle_cycles = 0;
		rows_reg = dpni_pkg::FRAME_ROWS_RST; cols_reg = dpni_pkg::FRAME_COLS_RST;
		hist_wp = 0;
		foreach (raw_hist[i]) raw_hist[i] = 0;
		restart_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// Directed: small frame with extremes, a flush at frame start with nothing
		// pending, a frame padded by a mid-frame flush, then a drain.
		write_reg(dpni_pkg::REG_FRAME_ROWS, 10'd3);
		write_reg(dpni_pkg::REG_FRAME_COLS, 10'd4);
		push_pixel(0, 1);
		foreach (dir_pix[i]) push_pixel(dir_pix[i], 0);
		push_pixel(0, 0); push_pixel(3, 0); push_pixel(0, 1);
		for (int i = 0; i < 9 + 6; i++) push_pixel(-1, 1);
		wait_drained();

		// Writes to unused indexes must leave the stream alone.
		write_reg(REG_SPARE_A, 10'h3FF);
		write_reg(REG_SPARE_B, 10'h155);

		// Degenerate sizes: zero acts as one, one by one.
		write_reg(dpni_pkg::REG_FRAME_ROWS, 10'd0);
		write_reg(dpni_pkg::REG_FRAME_COLS, 10'd0);
		run_frames(15, 5);
		write_reg(dpni_pkg::REG_FRAME_ROWS, 10'd1);
		write_reg(dpni_pkg::REG_FRAME_COLS, 10'd1);
		run_frames(10, 5);

		// Column register above MAX_COLS clamps to the widest frame.
		write_reg(dpni_pkg::REG_FRAME_ROWS, 10'd1);
		write_reg(dpni_pkg::REG_FRAME_COLS, 10'h3FF);
		run_frames(MAXC, 3);

		// Tallest frame, left partly filled before the next write restarts it.
		write_reg(dpni_pkg::REG_FRAME_COLS, 10'd3);
		write_reg(dpni_pkg::REG_FRAME_ROWS, 10'd1023);
		for (int i = 0; i < 20; i++) push_pixel(rand_pixel(), 0);
		while (pixel_feed.size() != 0 || pix_valid || corrected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		// Random small frames; one phase holds the output off for a long stretch.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(dpni_pkg::REG_FRAME_ROWS, DW'($urandom_range(1, 4)));
			write_reg(dpni_pkg::REG_FRAME_COLS, DW'($urandom_range(1, 8)));
			if (ph == 1) begin
				fork
					run_frames(40, 4);
					begin
						int unsigned held;
						hold_output = 1;
						for (held = 0; held < 400; held++) @(posedge clk);
						hold_output = 0;
					end
				join
			end else
				run_frames(15 + $urandom_range(0, 10), 4);
		end

		// Back to the reset size for a last partial frame.
		write_reg(dpni_pkg::REG_FRAME_ROWS, dpni_pkg::FRAME_ROWS_RST);
		write_reg(dpni_pkg::REG_FRAME_COLS, dpni_pkg::FRAME_COLS_RST);
		for (int i = 0; i < 90; i++) push_pixel(rand_pixel(), 0);
		while (pixel_feed.size() != 0 || pix_valid || corrected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d pixel transactions, checked %0d results over sizes from 1x1 up",
			items_sent, results_seen);
		$display("to a clamped 1x%0d row and 1023 rows, with a long output hold; %0d mismatches.",
			MAXC, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/core/dpni_pkg.sv
rtl/core/dpni_ram.sv
rtl/core/dpni_queue.sv
rtl/core/dpni_front.sv
rtl/core/dpni_div.sv
rtl/core/dpni_back.sv
rtl/core/dead_pixel_neighbour_interpolator_unit.sv
tb/tb_dead_pixel_neighbour_interpolator_unit.sv
